>>> rtl/binary_volume_centroid_assert.svh
// Assertion macros for the binary volume centroid checker.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef BINARY_VOLUME_CENTROID_ASSERT_SVH
`define BINARY_VOLUME_CENTROID_ASSERT_SVH

// Implication that must hold at every rising edge out of reset.
`define BVC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Same, but also checked while reset is low.
`define BVC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/bvc_pkg.sv
`default_nettype none
package bvc_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int FRAC_BITS = 8;

  localparam int POS_W  = $clog2(MAX_DIM);
  localparam int REG_W  = 11;
  localparam int IDX_W  = 2;
  localparam int VOX_W  = 16;
  localparam int SUM_W  = 40;
  localparam int CNT_W  = 31;
  localparam int CEN_W  = 18;
  localparam int DVD_W  = SUM_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DVD_W + 1);

  localparam logic [REG_W-1:0] SIZE_RESET = 11'd1024;

  // register indexes on the config channel
  localparam logic [IDX_W-1:0] REG_SIZE_X = 2'd0;
  localparam logic [IDX_W-1:0] REG_SIZE_Y = 2'd1;
  localparam logic [IDX_W-1:0] REG_SIZE_Z = 2'd2;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    ST_ACC       = 4'b0001,
    ST_DIV_START = 4'b0010,
    ST_DIV_WAIT  = 4'b0100,
    ST_HOLD      = 4'b1000
  } state_e;

  // last valid index of each axis
  typedef struct packed {
    logic [POS_W-1:0] last_x;
    logic [POS_W-1:0] last_y;
    logic [POS_W-1:0] last_z;
  } bvc_dims_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bvc_div_stat_t;

  // size register to last index: zero acts as one, oversize clamps to MAX_DIM
  function automatic logic [POS_W-1:0] last_index(input logic [REG_W-1:0] v);
    logic [POS_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = POS_W'(MAX_DIM - 1);
    end else begin
      r = POS_W'(v - 1'b1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/bvc_voxel_if.sv
`default_nettype none
interface bvc_voxel_if
  import bvc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VOX_W-1:0] voxel_value;

  modport source (output valid, output voxel_value, input ready);
  modport sink   (input valid, input voxel_value, output ready);
endinterface
`default_nettype wire

>>> rtl/bvc_result_if.sv
`default_nettype none
interface bvc_result_if
  import bvc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CEN_W-1:0] centroid_x;
  logic [CEN_W-1:0] centroid_y;
  logic [CEN_W-1:0] centroid_z;
  logic [CNT_W-1:0] object_count;
  logic             empty_volume;

  modport source (output valid, output centroid_x, output centroid_y, output centroid_z,
                  output object_count, output empty_volume, input ready);
  modport sink   (input valid, input centroid_x, input centroid_y, input centroid_z,
                  input object_count, input empty_volume, output ready);
endinterface
`default_nettype wire

>>> rtl/bvc_cfg_if.sv
`default_nettype none
interface bvc_cfg_if
  import bvc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [REG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bvc_accum.sv
`default_nettype none
module bvc_accum
  import bvc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             object_i,
  input  wire bvc_dims_t        dims_i,
  output logic                  last_o,
  output logic      [SUM_W-1:0] sum_x_o,
  output logic      [SUM_W-1:0] sum_y_o,
  output logic      [SUM_W-1:0] sum_z_o,
  output logic      [CNT_W-1:0] count_o
);

  logic [POS_W-1:0] pos_x_q, pos_x_d, pos_y_q, pos_y_d, pos_z_q, pos_z_d;
  logic [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d, sum_z_q, sum_z_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             end_x, end_y, end_z;

  // running totals including the current word
  always_comb begin
    sum_x_o = sum_x_q + (object_i ? SUM_W'(pos_x_q) : '0);
    sum_y_o = sum_y_q + (object_i ? SUM_W'(pos_y_q) : '0);
    sum_z_o = sum_z_q + (object_i ? SUM_W'(pos_z_q) : '0);
    count_o = cnt_q + CNT_W'(object_i);
  end

  // at-or-beyond counts as end, so a shrunk size mid-volume still wraps
  assign end_x  = pos_x_q >= dims_i.last_x;
  assign end_y  = pos_y_q >= dims_i.last_y;
  assign end_z  = pos_z_q >= dims_i.last_z;
  assign last_o = end_x && end_y && end_z;

  always_comb begin
    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    pos_z_d = pos_z_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    sum_z_d = sum_z_q;
    cnt_d   = cnt_q;
    if (step_i) begin
      if (last_o) begin
        pos_x_d = '0;
        pos_y_d = '0;
        pos_z_d = '0;
        sum_x_d = '0;
        sum_y_d = '0;
        sum_z_d = '0;
        cnt_d   = '0;
      end else begin
        sum_x_d = sum_x_o;
        sum_y_d = sum_y_o;
        sum_z_d = sum_z_o;
        cnt_d   = count_o;
        if (!end_x) begin
          pos_x_d = pos_x_q + 1'b1;
        end else begin
          pos_x_d = '0;
          if (!end_y) begin
            pos_y_d = pos_y_q + 1'b1;
          end else begin
            pos_y_d = '0;
            pos_z_d = pos_z_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      pos_z_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      sum_z_q <= '0;
      cnt_q   <= '0;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      pos_z_q <= pos_z_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      sum_z_q <= sum_z_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/bvc_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle. Quotient saturates to CEN_W bits.
module bvc_div
  import bvc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,   // held stable while busy
  output logic      [CEN_W-1:0] quotient_o,
  output bvc_div_stat_t         stat_o
);

  logic              busy_q, busy_d, done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CEN_W-1:0]  quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              fits;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[DVD_W-1]};
    rem_sub = rem_sh - {1'b0, divisor_i};
    fits    = rem_sh >= {1'b0, divisor_i};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    ovf_d  = ovf_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = STEP_W'(DVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      quo_d  = '0;
      ovf_d  = 1'b0;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[DVD_W-2:0], 1'b0};
      rem_d  = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_d  = {quo_q[CEN_W-2:0], fits};
      ovf_d  = ovf_q | quo_q[CEN_W-1];
      step_d = step_q - 1'b1;
      if (step_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign quotient_o  = ovf_q ? '1 : quo_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule
`default_nettype wire

>>> rtl/binary_volume_centroid.sv
// Binary volume centroid.
// voxel_i  : one signed 16-bit voxel per word, raster order (x fastest, then y, z).
//            Taken one word per cycle while the block accumulates; ready drops
//            from the last voxel of a volume until its result is registered.
// result_o : one word per volume: x/y/z centroid (8 fraction bits, truncated,
//            saturated), object count and an empty flag (centroids zero).
// cfg_i    : size_x/size_y/size_z at indexes 0..2, always ready; write only
//            while idle. Zero acts as one, oversize clamps to MAX_DIM.
// Sequencing: after the last voxel one shared serial divider runs three times,
//   once per axis on a DVD_W (48)-bit dividend; an empty volume skips the
//   divides and goes straight to the hold state ahead of the output register.
//   The next volume starts once the result sits in the output register.
// Stall: while a result waits, voxels keep flowing; a finished division that
//   finds the output register still full holds (ready low) until it drains.
// Reset: positions, sums and counts clear, sizes return to 1024, no result.
`default_nettype none
module binary_volume_centroid
  import bvc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bvc_cfg_if.sink    cfg_i,
  bvc_voxel_if.sink  voxel_i,
  bvc_result_if.source result_o
);

  // config registers
  logic [REG_W-1:0] size_x_q, size_y_q, size_z_q;
  bvc_dims_t        dims;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q <= SIZE_RESET;
      size_y_q <= SIZE_RESET;
      size_z_q <= SIZE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SIZE_X: size_x_q <= cfg_i.data;
        REG_SIZE_Y: size_y_q <= cfg_i.data;
        REG_SIZE_Z: size_z_q <= cfg_i.data;
        default: ; // unmapped index, dropped
      endcase
    end
  end

  always_comb begin
    dims.last_x = last_index(size_x_q);
    dims.last_y = last_index(size_y_q);
    dims.last_z = last_index(size_z_q);
  end

  // accumulation
  state_e           state_q, state_d;
  logic             accept, last;
  logic [SUM_W-1:0] acc_x, acc_y, acc_z;
  logic [CNT_W-1:0] acc_cnt;

  assign voxel_i.ready = (state_q == ST_ACC);
  assign accept        = voxel_i.valid && voxel_i.ready;

  bvc_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (accept),
    .object_i (voxel_i.voxel_value != '0),
    .dims_i   (dims),
    .last_o   (last),
    .sum_x_o  (acc_x),
    .sum_y_o  (acc_y),
    .sum_z_o  (acc_z),
    .count_o  (acc_cnt)
  );

  // snapshot of the finished volume, operands for the divider
  logic [SUM_W-1:0] op_x_q, op_y_q, op_z_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CEN_W-1:0] cen_x_q, cen_y_q, cen_z_q;
  axis_e            axis_q, axis_d;
  logic [SUM_W-1:0] op_sel;
  logic             div_start;
  logic [CEN_W-1:0] div_quo;
  bvc_div_stat_t    div_stat;

  always_comb begin
    case (axis_q)
      AXIS_X:  op_sel = op_x_q;
      AXIS_Y:  op_sel = op_y_q;
      AXIS_Z:  op_sel = op_z_q;
      default: op_sel = '0;
    endcase
  end

  bvc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DVD_W'(op_sel) << FRAC_BITS),
    .divisor_i  (cnt_q),
    .quotient_o (div_quo),
    .stat_o     (div_stat)
  );

  // output register
  logic out_valid_q, out_valid_d, out_load;

  // sequencer
  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    div_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !result_o.ready;
    case (state_q)
      ST_ACC: begin
        if (accept && last) begin
          axis_d  = AXIS_X;
          state_d = (acc_cnt == '0) ? ST_HOLD : ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          case (axis_q)
            AXIS_X: begin
              axis_d  = AXIS_Y;
              state_d = ST_DIV_START;
            end
            AXIS_Y: begin
              axis_d  = AXIS_Z;
              state_d = ST_DIV_START;
            end
            default: state_d = ST_HOLD;
          endcase
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || result_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      axis_q      <= AXIS_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  logic [CEN_W-1:0] res_x_q, res_y_q, res_z_q;
  logic [CNT_W-1:0] res_cnt_q;
  logic             res_empty_q;
  logic             empty;

  assign empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (accept && last) begin
      op_x_q <= acc_x;
      op_y_q <= acc_y;
      op_z_q <= acc_z;
      cnt_q  <= acc_cnt;
    end
    if (state_q == ST_DIV_WAIT && div_stat.done) begin
      case (axis_q)
        AXIS_X:  cen_x_q <= div_quo;
        AXIS_Y:  cen_y_q <= div_quo;
        default: cen_z_q <= div_quo;
      endcase
    end
    if (out_load) begin
      res_x_q     <= empty ? '0 : cen_x_q;
      res_y_q     <= empty ? '0 : cen_y_q;
      res_z_q     <= empty ? '0 : cen_z_q;
      res_cnt_q   <= cnt_q;
      res_empty_q <= empty;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.centroid_x   = res_x_q;
  assign result_o.centroid_y   = res_y_q;
  assign result_o.centroid_z   = res_z_q;
  assign result_o.object_count = res_cnt_q;
  assign result_o.empty_volume = res_empty_q;

endmodule
`default_nettype wire

>>> rtl/bvc_checker.sv
`default_nettype none
`include "binary_volume_centroid_assert.svh"
module bvc_checker
  import bvc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             res_valid_i,
  input wire logic             res_ready_i,
  input wire logic [CEN_W-1:0] cen_x_i,
  input wire logic [CEN_W-1:0] cen_y_i,
  input wire logic [CEN_W-1:0] cen_z_i,
  input wire logic [CNT_W-1:0] count_i,
  input wire logic             empty_i
);

  // a stalled result word holds
  `BVC_ASSERT(a_res_hold, res_valid_i && !res_ready_i |=> res_valid_i && $stable(cen_x_i) && $stable(cen_y_i) && $stable(cen_z_i) && $stable(count_i) && $stable(empty_i), "result word changed under stall")

  // empty flag means zero count and zero centroids
  `BVC_ASSERT(a_empty_zero, res_valid_i && empty_i |-> count_i == '0 && cen_x_i == '0 && cen_y_i == '0 && cen_z_i == '0, "empty result not all zero")

  // a nonempty result has a nonzero count
  `BVC_ASSERT(a_count_nonzero, res_valid_i && !empty_i |-> count_i != '0, "nonempty result with zero count")

endmodule

bind binary_volume_centroid bvc_checker u_bvc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (result_o.valid),
  .res_ready_i (result_o.ready),
  .cen_x_i     (result_o.centroid_x),
  .cen_y_i     (result_o.centroid_y),
  .cen_z_i     (result_o.centroid_z),
  .count_i     (result_o.object_count),
  .empty_i     (result_o.empty_volume)
);
`default_nettype wire

>>> sim/bvc_centroid_check.sv
`default_nettype none
module bvc_centroid_check
  import bvc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  bvc_cfg_if        cfg_i,
  bvc_voxel_if      voxel_i,
  bvc_result_if     result_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    logic [CEN_W-1:0] centroid_x;
    logic [CEN_W-1:0] centroid_y;
    logic [CEN_W-1:0] centroid_z;
    logic [CNT_W-1:0] object_count;
    logic             empty_volume;
  } volume_summary_t;

  logic [REG_W-1:0] size_x, size_y, size_z;
  int unsigned      col, row, slice;
  logic [SUM_W-1:0] acc_x, acc_y, acc_z;
  logic [CNT_W-1:0] hits;
  volume_summary_t  summary_q [$];
  int               mismatches;
  int               volumes_seen;

  // register value to axis length
  function automatic int unsigned axis_len(input logic [REG_W-1:0] code);
    if (code == '0) return 1;
    if (int'(code) > MAX_DIM) return MAX_DIM;
    return int'(code);
  endfunction

  // truncated mean with FRAC_BITS fraction bits, saturating
  function automatic logic [CEN_W-1:0] mean_pos(input logic [SUM_W-1:0] acc,
                                                input logic [CNT_W-1:0] n);
    logic [63:0] q;
    if (n == '0) return '0;
    q = ({24'd0, acc} << FRAC_BITS) / {33'd0, n};
    if (q > 64'({CEN_W{1'b1}})) return '1;
    return q[CEN_W-1:0];
  endfunction

  task automatic note_failure(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t ns: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : predict
    volume_summary_t got;
    volume_summary_t want;
    int unsigned     dx, dy, dz;
    if (!rst_ni) begin
      size_x = SIZE_RESET;
      size_y = SIZE_RESET;
      size_z = SIZE_RESET;
      col = 0;
      row = 0;
      slice = 0;
      acc_x = '0;
      acc_y = '0;
      acc_z = '0;
      hits = '0;
      summary_q.delete();
      mismatches = 0;
      volumes_seen = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_SIZE_X: size_x = cfg_i.data;
          REG_SIZE_Y: size_y = cfg_i.data;
          REG_SIZE_Z: size_z = cfg_i.data;
          default: ;
        endcase
      end

      if (result_i.valid && result_i.ready) begin
        got.centroid_x   = result_i.centroid_x;
        got.centroid_y   = result_i.centroid_y;
        got.centroid_z   = result_i.centroid_z;
        got.object_count = result_i.object_count;
        got.empty_volume = result_i.empty_volume;
        if (summary_q.size() == 0) begin
          note_failure($sformatf("unexpected result x=%0d y=%0d z=%0d count=%0d empty=%0b",
                                 got.centroid_x, got.centroid_y, got.centroid_z,
                                 got.object_count, got.empty_volume));
        end else begin
          want = summary_q.pop_front();
          if (got.centroid_x !== want.centroid_x || got.centroid_y !== want.centroid_y ||
              got.centroid_z !== want.centroid_z ||
              got.object_count !== want.object_count ||
              got.empty_volume !== want.empty_volume) begin
            note_failure($sformatf(
              "volume %0d: expected x=%0d y=%0d z=%0d count=%0d empty=%0b, got x=%0d y=%0d z=%0d count=%0d empty=%0b",
              volumes_seen, want.centroid_x, want.centroid_y, want.centroid_z,
              want.object_count, want.empty_volume, got.centroid_x, got.centroid_y,
              got.centroid_z, got.object_count, got.empty_volume));
          end
          volumes_seen++;
        end
      end

      if (voxel_i.valid && voxel_i.ready) begin
        dx = axis_len(size_x);
        dy = axis_len(size_y);
        dz = axis_len(size_z);
        if (voxel_i.voxel_value != '0) begin
          acc_x = acc_x + SUM_W'(col);
          acc_y = acc_y + SUM_W'(row);
          acc_z = acc_z + SUM_W'(slice);
          hits  = hits + 1'b1;
        end
        if (col >= dx - 1 && row >= dy - 1 && slice >= dz - 1) begin
          // last voxel: one summary word per volume
          want.empty_volume = (hits == '0);
          want.object_count = hits;
          want.centroid_x   = want.empty_volume ? '0 : mean_pos(acc_x, hits);
          want.centroid_y   = want.empty_volume ? '0 : mean_pos(acc_y, hits);
          want.centroid_z   = want.empty_volume ? '0 : mean_pos(acc_z, hits);
          summary_q.push_back(want);
          col = 0;
          row = 0;
          slice = 0;
          acc_x = '0;
          acc_y = '0;
          acc_z = '0;
          hits = '0;
        end else if (col < dx - 1) begin
          col++;
        end else begin
          col = 0;
          if (row < dy - 1) begin
            row++;
          end else begin
            row = 0;
            slice++;
          end
        end
      end
    end
    pending_o    <= summary_q.size();
    fail_count_o <= mismatches;
  end

endmodule
`default_nettype wire

>>> sim/binary_volume_centroid_test.sv
`default_nettype none
// Top of the centroid regression. Makes stimulus only: config writes, voxel
// words and result back-pressure. bvc_centroid_check watches all three
// channels, predicts one summary word per volume and counts mismatches.
module binary_volume_centroid_test;
  import bvc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES  = 6;
  // worst case is every voxel its own volume and setting: ~650 x (drain
  // + divides and stalls); the limit is several times that
  localparam int CYCLE_LIMIT   = 1_500_000;
  // longer than the 3 serial divides take
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_VOXELS = 620;

  // index 3 is not a register; writes there must change nothing
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  int idle_pct   = 0;   // chance the voxel source idles a cycle
  int stall_pct  = 0;   // chance the result sink drops ready
  int cycle_count = 0;
  int fail_count;
  int pending;
  int vol_voxels;       // voxels per volume under the current sizes
  int voxels_sent = 0;

  bvc_cfg_if    cfg_if ();
  bvc_voxel_if  voxel_if ();
  bvc_result_if result_if ();

  binary_volume_centroid DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .voxel_i  (voxel_if),
    .result_o (result_if)
  );

  bvc_centroid_check centroid_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_if),
    .voxel_i      (voxel_if),
    .result_i     (result_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result sink: random back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    result_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // idling profile: 0 none, 1 source gaps, 2 sink stalls, 3 light on both
  task automatic set_pressure(input int phase);
    case (phase % 4)
      0: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      1: begin
        idle_pct = 49;
        stall_pct <= 0;
      end
      2: begin
        idle_pct = 0;
        stall_pct <= 49;
      end
      default: begin
        idle_pct = 9;
        stall_pct <= 9;
      end
    endcase
  endtask

  // Leaves cfg valid high; the caller drops it after its last write so that
  // back-to-back writes never lower and raise valid in one step.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  // Stop voxels, let every summary word come back, then let the block settle.
  task automatic wait_idle();
    voxel_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Only written between volumes, with nothing outstanding.
  task automatic configure(input logic [REG_W-1:0] code_x, code_y, code_z,
                           input int dim_x, dim_y, dim_z, input bit spare,
                           input int phase);
    wait_idle();
    set_pressure(phase);
    write_reg(REG_SIZE_X, code_x);
    if (spare) write_reg(REG_UNUSED, REG_W'($urandom));
    write_reg(REG_SIZE_Y, code_y);
    write_reg(REG_SIZE_Z, code_z);
    cfg_if.valid <= 1'b0;
    vol_voxels = dim_x * dim_y * dim_z;
  endtask

  // Valid stays high after the handshake; next word or wait_idle decides.
  task automatic send_voxel(input logic [VOX_W-1:0] value);
    if ($urandom_range(99) < idle_pct) begin
      voxel_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    voxel_if.valid       <= 1'b1;
    voxel_if.voxel_value <= value;
    do @(posedge clk_i); while (!voxel_if.ready);
    voxels_sent++;
  endtask

  // density: percent of voxels that are object (nonzero)
  function automatic logic [VOX_W-1:0] random_voxel(input int density);
    logic [VOX_W-1:0] v;
    v = VOX_W'($urandom_range(1, 65535));
    if ($urandom_range(99) >= density) v = '0;
    return v;
  endfunction

  task automatic send_volume(input int density);
    for (int i = 0; i < vol_voxels; i++) send_voxel(random_voxel(density));
  endtask

  // axis length 1 is written as 0 half the time (zero acts as one)
  function automatic logic [REG_W-1:0] size_code(input int dim);
    if (dim == 1 && $urandom_range(1) == 1) return '0;
    return REG_W'(dim);
  endfunction

  // mostly tiny axes so each volume ends quickly, sometimes up to hi
  function automatic int pick_dim(input int hi);
    if ($urandom_range(99) < 65) return $urandom_range(1, 3);
    return $urandom_range(1, hi);
  endfunction

  function automatic int pick_density();
    case ($urandom_range(4))
      0: return 0;
      1: return 10;
      2: return 50;
      3: return 90;
      default: return 100;
    endcase
  endfunction

  initial begin : stimulus
    logic [VOX_W-1:0] corner_words [8];
    int random_start;
    int setting;
    int dx, dy, dz;

    corner_words = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001,
                     16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA};

    rst_ni               <= 1'b0;
    cfg_if.valid         <= 1'b0;
    cfg_if.index         <= REG_SIZE_X;
    cfg_if.data          <= '0;
    voxel_if.valid       <= 1'b0;
    voxel_if.voxel_value <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 2x2x2: sample extremes, then an empty volume, then a full one
    configure(11'd2, 11'd2, 11'd2, 2, 2, 2, 1'b0, 0);
    foreach (corner_words[i]) send_voxel(corner_words[i]);
    send_volume(0);
    send_volume(100);

    // all sizes zero -> single-voxel volumes; spare index written too
    configure('0, '0, '0, 1, 1, 1, 1'b1, 1);
    send_voxel(16'h0100);
    send_voxel('0);

    // random sizes, densities and idling profiles
    random_start = voxels_sent;
    setting = 0;
    while (voxels_sent - random_start < RANDOM_VOXELS) begin
      dx = pick_dim(16);
      dy = pick_dim(4);
      dz = pick_dim(4);
      configure(size_code(dx), size_code(dy), size_code(dz), dx, dy, dz,
                $urandom_range(4) == 0, setting);
      repeat ($urandom_range(1, 4)) send_volume(pick_density());
      setting++;
    end

    wait_idle();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
+incdir+rtl
rtl/bvc_pkg.sv
rtl/bvc_voxel_if.sv
rtl/bvc_result_if.sv
rtl/bvc_cfg_if.sv
rtl/bvc_accum.sv
rtl/bvc_div.sv
rtl/binary_volume_centroid.sv
rtl/bvc_checker.sv
sim/bvc_centroid_check.sv
sim/binary_volume_centroid_test.sv
